// File: src/scw_pkg.sv
// Shared types, constants and the power table for the soft-clip waveshaper.
`default_nettype none
package scw_pkg;

    localparam int SAMPLE_W = 24;
    localparam int FRAC_B   = SAMPLE_W - 1;
    localparam int P_W      = SAMPLE_W + 24;

    localparam logic [30:0] ONE30    = 31'h4000_0000;
    localparam logic [31:0] TWO30    = 32'h8000_0000;
    localparam logic [31:0] PI30     = 32'd3373259426;
    localparam logic [31:0] HALFPI30 = 32'd1686629713;
    localparam logic [15:0] DRIVE_MIN = 16'd4096;
    localparam logic [15:0] DRIVE_MAX = 16'd40960;

    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_GAIN   = 3'd1;
    localparam logic [2:0] CFG_DRIVE  = 3'd2;
    localparam logic [2:0] CFG_PHASE  = 3'd3;
    localparam logic [2:0] CFG_INVSIN = 3'd4;
    localparam logic [2:0] CFG_OSCALE = 3'd5;

    localparam int LOG_CELLS = 24;
    localparam int EXP_CELLS = 24;
    localparam int SIN_CELLS = 6;
    localparam int A_DELAY   = 29;
    localparam int CTL_DEPTH = 55;

    localparam logic [7:0] HORNER_DIV [SIN_CELLS] =
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] HORNER_RECIP [SIN_CELLS] = '{
        32'((64'd1 << 34) / 64'd156),
        32'((64'd1 << 34) / 64'd110),
        32'((64'd1 << 34) / 64'd72),
        32'((64'd1 << 34) / 64'd42),
        32'((64'd1 << 34) / 64'd20),
        32'((64'd1 << 34) / 64'd6)
    };

    typedef logic [EXP_CELLS:0][31:0] t_pow_tab;

    typedef struct packed {
        logic valid;
        logic neg;
        logic clip;
    } t_ctl;

    typedef struct packed {
        logic [30:0] w;
        logic        sneg;
        logic [31:0] w2;
    } t_sin_side;

    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = '0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_pow_tab f_pow_tab();
        t_pow_tab t;
        t = '0;
        t[1] = 32'(f_isqrt(64'd1 << 59));
        for (int i = 2; i <= EXP_CELLS; i++) begin
            t[i] = 32'(f_isqrt({32'd0, t[i-1]} << 30));
        end
        return t;
    endfunction

    localparam t_pow_tab POW_TAB = f_pow_tab();

endpackage
`default_nettype wire

// File: src/scw_log_cell.sv
// One squaring step of the base-2 logarithm chain.
`default_nettype none
module scw_log_cell (
    input  wire logic        i_clk,
    input  wire logic [30:0] i_m,
    input  wire logic [23:0] i_f,
    input  wire logic [4:0]  i_lz,
    output logic      [30:0] o_m,
    output logic      [23:0] o_f,
    output logic      [4:0]  o_lz
);
    logic [63:0] n_sq;
    logic [31:0] n_s;
    logic [30:0] n_m;
    logic [23:0] n_f;
    logic [30:0] r_m;
    logic [23:0] r_f;
    logic [4:0]  r_lz;

    always_comb begin
        n_sq = 64'(i_m) * 64'(i_m);
        n_s  = 32'(n_sq >> 30);
        if (n_s[31]) begin
            n_m = n_s[31:1];
            n_f = {i_f[22:0], 1'b1};
        end else begin
            n_m = n_s[30:0];
            n_f = {i_f[22:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_m  <= n_m;
        r_f  <= n_f;
        r_lz <= i_lz;
    end

    assign o_m  = r_m;
    assign o_f  = r_f;
    assign o_lz = r_lz;
endmodule
`default_nettype wire

// File: src/scw_exp_cell.sv
// One conditional multiply of the power-of-two chain.
`default_nettype none
module scw_exp_cell (
    input  wire logic        i_clk,
    input  wire logic [30:0] i_r,
    input  wire logic [23:0] i_g,
    input  wire logic [5:0]  i_n,
    input  wire logic [29:0] i_c,
    output logic      [30:0] o_r,
    output logic      [23:0] o_g,
    output logic      [5:0]  o_n
);
    logic [63:0] n_prod;
    logic [30:0] n_r;
    logic [30:0] r_r;
    logic [23:0] r_g;
    logic [5:0]  r_n;

    always_comb begin
        n_prod = 64'(i_r) * 64'(i_c);
        n_r    = i_g[23] ? 31'(n_prod >> 30) : i_r;
    end

    always_ff @(posedge i_clk) begin
        r_r <= n_r;
        r_g <= {i_g[22:0], 1'b0};
        r_n <= i_n;
    end

    assign o_r = r_r;
    assign o_g = r_g;
    assign o_n = r_n;
endmodule
`default_nettype wire

// File: src/scw_sin_cell.sv
// One Horner step of the sine series, three register stages.
`default_nettype none
module scw_sin_cell (
    input  wire logic                 i_clk,
    input  wire scw_pkg::t_sin_side   i_side,
    input  wire logic [30:0]          i_t,
    input  wire logic [7:0]           i_k,
    input  wire logic [31:0]          i_recip,
    output scw_pkg::t_sin_side        o_side,
    output logic      [30:0]          o_t
);
    scw_pkg::t_sin_side r_side_a;
    scw_pkg::t_sin_side r_side_b;
    scw_pkg::t_sin_side r_side_c;
    logic [31:0] n_x;
    logic [31:0] r_x;
    logic [31:0] r_xb;
    logic [29:0] n_qa;
    logic [29:0] r_qa;
    logic [37:0] n_rem;
    logic [29:0] n_q;
    logic [30:0] r_t;

    always_comb begin
        n_x   = 32'((64'(i_side.w2) * 64'(i_t)) >> 30);
        n_qa  = 30'((64'(r_x) * 64'(i_recip)) >> 34);
        n_rem = 38'(r_xb) - 38'(r_qa) * 38'(i_k);
        n_q   = (n_rem >= 38'(i_k)) ? r_qa + 30'd1 : r_qa;
    end

    always_ff @(posedge i_clk) begin
        r_side_a <= i_side;
        r_x      <= n_x;
        r_side_b <= r_side_a;
        r_xb     <= r_x;
        r_qa     <= n_qa;
        r_side_c <= r_side_b;
        r_t      <= scw_pkg::ONE30 - 31'(n_q);
    end

    assign o_side = r_side_c;
    assign o_t    = r_t;
endmodule
`default_nettype wire

// File: src/soft_clip_waveshaper_core.sv
// Top level of the soft-clip waveshaper: gain, curve chains, clip and saturation.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | start, busy          | i_sample_in
//  result   | o_done               | o_sample_out
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One sample enters every cycle; busy stays low. The delay from each transfer to its
// result is set by the 24-step logarithm and 24-step power chains
// of the exponential curve; the sine path is padded to the same length.
// Synchronous active-low reset clears the valid line and loads the register
// defaults. The receiver cannot stall; results leave on o_done for one cycle.
`default_nettype none
module soft_clip_waveshaper_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [scw_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                     o_done,
    output logic signed      [scw_pkg::SAMPLE_W-1:0] o_sample_out,
    input  wire logic                                i_cfg_we,
    input  wire logic        [2:0]                   i_cfg_idx,
    input  wire logic        [31:0]                  i_cfg_data
);
    localparam int SW = scw_pkg::SAMPLE_W;
    localparam int FB = scw_pkg::FRAC_B;
    localparam int PW = scw_pkg::P_W;

    logic        r_mode;
    logic [23:0] r_gain;
    logic [15:0] r_drive;
    logic [23:0] r_phase;
    logic [31:0] r_inv;
    logic [23:0] r_oscale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b1;
            r_gain   <= 24'd65536;
            r_drive  <= 16'd12288;
            r_phase  <= 24'd2926709;
            r_inv    <= 32'd1632024;
            r_oscale <= 24'd8388608;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                scw_pkg::CFG_MODE:   r_mode   <= i_cfg_data[0];
                scw_pkg::CFG_GAIN:   r_gain   <= i_cfg_data[23:0];
                scw_pkg::CFG_DRIVE:  r_drive  <= i_cfg_data[15:0];
                scw_pkg::CFG_PHASE:  r_phase  <= i_cfg_data[23:0];
                scw_pkg::CFG_INVSIN: r_inv    <= i_cfg_data;
                scw_pkg::CFG_OSCALE: r_oscale <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // control line
    scw_pkg::t_ctl r_ctl [scw_pkg::CTL_DEPTH];
    logic [SW-1:0] w_raw;
    logic [SW-1:0] n_mag;
    logic [PW-1:0] r_p;
    logic [29:0]   r_a2;

    assign w_raw = i_sample_in;
    assign n_mag = w_raw[SW-1] ? (~w_raw + SW'(1)) : w_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < scw_pkg::CTL_DEPTH; k++) begin
                r_ctl[k] <= '0;
            end
        end else begin
            r_ctl[0].valid <= start && !busy;
            r_ctl[0].neg   <= w_raw[SW-1];
            r_ctl[0].clip  <= 1'b0;
            r_ctl[1].valid <= r_ctl[0].valid;
            r_ctl[1].neg   <= r_ctl[0].neg;
            r_ctl[1].clip  <= |r_p[PW-1:FB+16];
            for (int k = 2; k < scw_pkg::CTL_DEPTH; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p  <= PW'(n_mag) * PW'(r_gain);
        r_a2 <= r_p[FB+15:FB-14];
    end

    // exponential curve: normalize, logarithm, scale, power
    logic [30:0] n_u;
    logic [4:0]  n_k;
    logic [30:0] r_u;
    logic [4:0]  r_lz;
    logic [30:0] r_mn;
    logic [4:0]  r_lz2;

    always_comb begin
        n_u = scw_pkg::ONE30 - {1'b0, r_a2};
        n_k = '0;
        for (int j = 0; j < 31; j++) begin
            if (n_u[j]) begin
                n_k = 5'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_u   <= n_u;
        r_lz  <= 5'd30 - n_k;
        r_mn  <= r_u << r_lz;
        r_lz2 <= r_lz;
    end

    logic [30:0] w_lm  [scw_pkg::LOG_CELLS+1];
    logic [23:0] w_lf  [scw_pkg::LOG_CELLS+1];
    logic [4:0]  w_llz [scw_pkg::LOG_CELLS+1];

    assign w_lm[0]  = r_mn;
    assign w_lf[0]  = '0;
    assign w_llz[0] = r_lz2;

    for (genvar i = 0; i < scw_pkg::LOG_CELLS; i++) begin : g_log
        scw_log_cell u_cell (
            .i_clk (i_clk),
            .i_m   (w_lm[i]),
            .i_f   (w_lf[i]),
            .i_lz  (w_llz[i]),
            .o_m   (w_lm[i+1]),
            .o_f   (w_lf[i+1]),
            .o_lz  (w_llz[i+1])
        );
    end

    logic [28:0] r_l;
    logic [15:0] n_d;
    logic [32:0] n_e;
    logic [23:0] r_g;
    logic [5:0]  r_nsat;

    always_comb begin
        n_d = r_drive;
        if (n_d < scw_pkg::DRIVE_MIN) begin
            n_d = scw_pkg::DRIVE_MIN;
        end
        if (n_d > scw_pkg::DRIVE_MAX) begin
            n_d = scw_pkg::DRIVE_MAX;
        end
        n_e = 33'((45'(r_l) * 45'(n_d)) >> 12);
    end

    always_ff @(posedge i_clk) begin
        r_l    <= {w_llz[scw_pkg::LOG_CELLS], 24'd0}
                  - {5'd0, w_lf[scw_pkg::LOG_CELLS]};
        r_g    <= n_e[23:0];
        r_nsat <= {(n_e[32:24] >= 9'd31), n_e[28:24]};
    end

    logic [30:0] w_er [scw_pkg::EXP_CELLS+1];
    logic [23:0] w_eg [scw_pkg::EXP_CELLS+1];
    logic [5:0]  w_en [scw_pkg::EXP_CELLS+1];

    assign w_er[0] = scw_pkg::ONE30;
    assign w_eg[0] = r_g;
    assign w_en[0] = r_nsat;

    for (genvar i = 0; i < scw_pkg::EXP_CELLS; i++) begin : g_exp
        scw_exp_cell u_cell (
            .i_clk (i_clk),
            .i_r   (w_er[i]),
            .i_g   (w_eg[i]),
            .i_n   (w_en[i]),
            .i_c   (scw_pkg::POW_TAB[i+1][29:0]),
            .o_r   (w_er[i+1]),
            .o_g   (w_eg[i+1]),
            .o_n   (w_en[i+1])
        );
    end

    logic [30:0] r_q0;

    always_ff @(posedge i_clk) begin
        r_q0 <= w_en[scw_pkg::EXP_CELLS][5] ? scw_pkg::ONE30
              : scw_pkg::ONE30 - (w_er[scw_pkg::EXP_CELLS]
                                  >> w_en[scw_pkg::EXP_CELLS][4:0]);
    end

    // sine curve: align, phase, range reduction, series, scaling
    logic [29:0] r_adly [scw_pkg::A_DELAY];
    logic [31:0] r_phi;
    logic [31:0] n_w;
    logic        n_sneg;
    logic [30:0] r_w;
    logic        r_sneg;
    scw_pkg::t_sin_side r_side0;

    always_ff @(posedge i_clk) begin
        r_adly[0] <= r_a2;
        for (int k = 1; k < scw_pkg::A_DELAY; k++) begin
            r_adly[k] <= r_adly[k-1];
        end
    end

    always_comb begin
        n_sneg = 1'b0;
        if (r_phi <= scw_pkg::HALFPI30) begin
            n_w = r_phi;
        end else if (r_phi <= scw_pkg::PI30) begin
            n_w = scw_pkg::PI30 - r_phi;
        end else begin
            n_w    = r_phi - scw_pkg::PI30;
            n_sneg = 1'b1;
        end
        if (n_w > scw_pkg::HALFPI30) begin
            n_w = scw_pkg::HALFPI30;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phi        <= 32'((64'(r_phase) * 64'(r_adly[scw_pkg::A_DELAY-1])) >> 22);
        r_w          <= 31'(n_w);
        r_sneg       <= n_sneg;
        r_side0.w    <= r_w;
        r_side0.sneg <= r_sneg;
        r_side0.w2   <= 32'((64'(r_w) * 64'(r_w)) >> 30);
    end

    scw_pkg::t_sin_side w_hs [scw_pkg::SIN_CELLS+1];
    logic [30:0]        w_ht [scw_pkg::SIN_CELLS+1];

    assign w_hs[0] = r_side0;
    assign w_ht[0] = scw_pkg::ONE30;

    for (genvar i = 0; i < scw_pkg::SIN_CELLS; i++) begin : g_sin
        scw_sin_cell u_cell (
            .i_clk   (i_clk),
            .i_side  (w_hs[i]),
            .i_t     (w_ht[i]),
            .i_k     (scw_pkg::HORNER_DIV[i]),
            .i_recip (scw_pkg::HORNER_RECIP[i]),
            .o_side  (w_hs[i+1]),
            .o_t     (w_ht[i+1])
        );
    end

    logic [30:0] r_sin;
    logic        r_sneg4;
    logic [38:0] r_v;
    logic        r_sneg5;
    logic [43:0] r_q1;
    logic        r_sneg6;

    always_ff @(posedge i_clk) begin
        r_sin   <= 31'((64'(w_hs[scw_pkg::SIN_CELLS].w)
                        * 64'(w_ht[scw_pkg::SIN_CELLS])) >> 30);
        r_sneg4 <= w_hs[scw_pkg::SIN_CELLS].sneg;
        r_v     <= 39'((64'(r_sin) * 64'(r_inv)) >> 24);
        r_sneg5 <= r_sneg4;
        r_q1    <= 44'((64'(r_v) * 64'(r_oscale)) >> 19);
        r_sneg6 <= r_sneg5;
    end

    // clip select, cap, sign and saturate
    scw_pkg::t_ctl w_ctl;
    logic [43:0]   n_q;
    logic [31:0]   n_qc;
    logic [SW:0]   n_m;
    logic [SW:0]   n_mm;
    logic          n_neg;
    logic [SW-1:0] n_code;
    logic          r_done;
    logic [SW-1:0] r_out;

    assign w_ctl = r_ctl[scw_pkg::CTL_DEPTH-1];

    always_comb begin
        if (w_ctl.clip) begin
            n_q = r_mode ? 44'({r_oscale, 7'd0}) : 44'(scw_pkg::ONE30);
        end else begin
            n_q = r_mode ? r_q1 : 44'(r_q0);
        end
        n_qc  = (n_q > 44'(scw_pkg::TWO30)) ? scw_pkg::TWO30 : n_q[31:0];
        n_m   = (SW+1)'(n_qc >> (30 - FB));
        n_neg = w_ctl.neg ^ (r_mode && !w_ctl.clip && r_sneg6);
        if (n_m == '0) begin
            n_neg = 1'b0;
        end
        if (n_neg) begin
            n_mm   = (n_m > ((SW+1)'(1) << FB)) ? ((SW+1)'(1) << FB) : n_m;
            n_code = SW'(((SW+1)'(1) << SW) - n_mm);
        end else begin
            n_mm   = (n_m >= ((SW+1)'(1) << FB)) ? (((SW+1)'(1) << FB) - (SW+1)'(1)) : n_m;
            n_code = SW'(n_mm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_code;
    end

    assign o_done       = r_done;
    assign o_sample_out = r_out;

    a_latency_fwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##56 o_done)
        else $error("accepted sample produced no result");

    a_latency_back : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 56))
        else $error("result without matching sample");

    a_ctl_flow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[1].valid |=> r_ctl[2].valid)
        else $error("valid lost in control line");
endmodule
`default_nettype wire
